// ===== rtl/mrs_pkg.sv =====
package mrs_pkg;

  localparam int CMD_W    = 2;
  localparam int CRIT_W   = 4;
  localparam int PROF_W   = 3;
  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 20;
  localparam int PIU_W    = 3;
  localparam int CAT_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_PROFILE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILES = 2'd1;

  localparam logic [SUM_W-1:0] LAMBDA_RESET = 20'd32768;
  localparam logic [PIU_W-1:0] PIU_RESET    = 3'd1;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD_W,
    OP_LOAD_P,
    OP_CLASSIFY
  } op_kind_t;

  typedef struct packed {
    op_kind_t                   kind;
    logic                       crit_ok;
    logic [CRIT_W-1:0]          criterion;
    logic [PROF_W-1:0]          profile;
    logic signed [VALUE_W-1:0]  value;
    logic [WEIGHT_W-1:0]        weight;
    logic                       last;
  } op_t;

endpackage

// ===== rtl/mrs_front.sv =====
module mrs_front import mrs_pkg::*; #(
  parameter int MAX_CRITERIA = 16,
  parameter int MAX_PROFILES = 7
) (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CMD_W-1:0]          command,
  input  logic [CRIT_W-1:0]         criterion,
  input  logic [PROF_W-1:0]         profile,
  input  logic signed [VALUE_W-1:0] perf_value,
  input  logic [WEIGHT_W-1:0]       weight,
  input  logic                      last,
  input  logic                      q_full,
  output logic                      push,
  output op_t                       op
);

  logic crit_ok;
  logic prof_ok;
  logic keep;

  assign crit_ok = 32'(criterion) < 32'(MAX_CRITERIA);
  assign prof_ok = 32'(profile) < 32'(MAX_PROFILES);

  // ignored words are taken and dropped here
  always_comb begin
    keep = 1'b0;
    op.kind      = OP_CLASSIFY;
    op.crit_ok   = crit_ok;
    op.criterion = criterion;
    op.profile   = profile;
    op.value     = perf_value;
    op.weight    = weight;
    op.last      = last;
    case (command)
      CMD_LOAD_WEIGHT: begin
        op.kind = OP_LOAD_W;
        keep = crit_ok;
      end
      CMD_LOAD_PROFILE: begin
        op.kind = OP_LOAD_P;
        keep = crit_ok && prof_ok;
      end
      CMD_CLASSIFY: begin
        op.kind = OP_CLASSIFY;
        keep = crit_ok || last;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && keep;

endmodule

// ===== rtl/mrs_queue.sv =====
module mrs_queue import mrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  din,
  output logic full,
  input  logic pop,
  output op_t  dout,
  output logic nonempty
);

  op_t            slots [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full     = count == QCW'(QDEPTH);
  assign nonempty = count != '0;
  assign dout     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/mrs_back.sv =====
module mrs_back import mrs_pkg::*; #(
  parameter int MAX_CRITERIA = 16,
  parameter int MAX_PROFILES = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  op_t              head,
  input  logic             head_valid,
  output logic             pop,
  input  logic [SUM_W-1:0] lambda,
  input  logic [PIU_W-1:0] piu,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CAT_W-1:0] category
);

  localparam int CW  = (MAX_CRITERIA > 1) ? $clog2(MAX_CRITERIA) : 1;
  localparam int XW  = (CW > CRIT_W) ? CW : CRIT_W;
  localparam int PD  = MAX_PROFILES * MAX_CRITERIA;
  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
  localparam int PIW = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;
  localparam int PW  = $clog2(MAX_PROFILES + 1);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;

  logic [WEIGHT_W-1:0]       wt_mem   [MAX_CRITERIA];
  logic signed [VALUE_W-1:0] prof_mem [PD];
  logic [WEIGHT_W-1:0]       wt_q;
  logic signed [VALUE_W-1:0] prof_q;

  logic [SUM_W-1:0] sums [MAX_PROFILES];

  logic [CW-1:0]             cur_crit;
  logic signed [VALUE_W-1:0] cur_value;
  logic                      cur_last;
  logic [PIW-1:0]            rd_p;
  logic [PIW-1:0]            sum_p;
  logic                      acc_v;
  logic [PW-1:0]             cat;

  logic [XW-1:0]  head_crit_x;
  logic [CW-1:0]  head_crit;
  logic [PAW-1:0] wr_addr;
  logic [PAW-1:0] rd_addr;
  logic [PW-1:0]  n_eff;
  logic [PIW-1:0] n_last;
  logic [SUM_W:0] sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic           can_emit;
  logic           all_zero;

  assign head_crit_x = XW'(head.criterion);
  assign head_crit   = head_crit_x[CW-1:0];

  assign n_eff  = PW'((32'(piu) > 32'(MAX_PROFILES)) ? 32'(MAX_PROFILES) : 32'(piu));
  assign n_last = PIW'(32'(n_eff) - 32'd1);

  assign wr_addr = PAW'(32'(head.profile) * 32'(MAX_CRITERIA) + 32'(head_crit));
  assign rd_addr = PAW'(32'(rd_p) * 32'(MAX_CRITERIA) + 32'(cur_crit));

  assign pop      = (state == S_IDLE) && head_valid;
  assign can_emit = !out_valid || out_ready;

  assign sum_add = {1'b0, sums[sum_p]} + (SUM_W + 1)'(wt_q);
  assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  always_comb begin
    all_zero = 1'b1;
    for (int i = 0; i < MAX_PROFILES; i++) begin
      if (sums[i] != '0) begin
        all_zero = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == OP_LOAD_W) begin
      wt_mem[head_crit] <= head.weight;
    end
    wt_q <= wt_mem[cur_crit];
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == OP_LOAD_P) begin
      prof_mem[wr_addr] <= head.value;
    end
    prof_q <= prof_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc_v     <= 1'b0;
      rd_p      <= '0;
      sum_p     <= '0;
      for (int i = 0; i < MAX_PROFILES; i++) begin
        sums[i] <= '0;
      end
    end else begin
      acc_v <= 1'b0;
      // a new result in the same cycle keeps the register full
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      // compare lands in the cycle after the profile read
      if (acc_v && (cur_value > prof_q)) begin
        sums[sum_p] <= sum_sat;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur_crit  <= head_crit;
            cur_value <= head.value;
            cur_last  <= head.last;
            if (head.kind == OP_CLASSIFY) begin
              if (head.crit_ok && n_eff != '0) begin
                rd_p  <= '0;
                state <= S_RUN;
              end else if (head.last) begin
                if (n_eff == '0) begin
                  cat   <= '0;
                  state <= S_EMIT;
                end else begin
                  sum_p <= n_last;
                  state <= S_SCAN;
                end
              end
            end
          end
        end
        S_RUN: begin
          acc_v <= 1'b1;
          sum_p <= rd_p;
          if (rd_p == n_last) begin
            state <= S_DRAIN;
          end else begin
            rd_p <= rd_p + 1'b1;
          end
        end
        S_DRAIN: begin
          if (cur_last) begin
            sum_p <= n_last;
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // highest profile first
          if (sums[sum_p] >= lambda) begin
            cat   <= PW'(32'(sum_p) + 32'd1);
            state <= S_EMIT;
          end else if (sum_p == '0) begin
            cat   <= '0;
            state <= S_EMIT;
          end else begin
            sum_p <= sum_p - 1'b1;
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            category  <= CAT_W'(cat);
            for (int i = 0; i < MAX_PROFILES; i++) begin
              sums[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && can_emit) |=> all_zero)
    else $error("concordance sums not cleared after result");

  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    acc_v |-> (32'(sum_p) < 32'(n_eff)))
    else $error("accumulation outside profiles in use");

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (32'(rd_p) < 32'(n_eff)))
    else $error("profile read outside profiles in use");

  a_cat_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && can_emit) |=> (32'(category) <= 32'(n_eff)))
    else $error("category above profiles in use");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN || state == S_SCAN) |-> !pop)
    else $error("queue popped while back end busy");

endmodule

// ===== rtl/majority_rule_sort_classifier.sv =====
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    command criterion profile perf_value weight last
// out      out  out_valid / out_ready  category
// cfg      in   cfg_valid / cfg_ready  cfg_index cfg_data (0 lambda, 1 profiles in use)
//
// Loads are written in the back end as they are popped in idle; a classify word with a
// valid criterion does one profile-table read per profile in use. A word marked last
// adds a threshold scan, highest profile first, and a step to post the result.
// rst is synchronous; it clears control state and the concordance sums, tables are
// undefined until loaded. A two-word queue parts the front from the back, and the
// output register lets the back finish the next word while a result waits.
module majority_rule_sort_classifier import mrs_pkg::*; #(
  parameter int MAX_CRITERIA = 16,
  parameter int MAX_PROFILES = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CMD_W-1:0]          command,
  input  logic [CRIT_W-1:0]         criterion,
  input  logic [PROF_W-1:0]         profile,
  input  logic signed [VALUE_W-1:0] perf_value,
  input  logic [WEIGHT_W-1:0]       weight,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CAT_W-1:0]          category,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SUM_W-1:0]          cfg_data
);

  logic [SUM_W-1:0] lambda;
  logic [PIU_W-1:0] piu;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nonempty;
  op_t  q_din;
  op_t  q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda <= LAMBDA_RESET;
      piu    <= PIU_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LAMBDA:   lambda <= cfg_data;
        CFG_PROFILES: piu    <= cfg_data[PIU_W-1:0];
        default: ;
      endcase
    end
  end

  mrs_front #(
    .MAX_CRITERIA(MAX_CRITERIA),
    .MAX_PROFILES(MAX_PROFILES)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .criterion (criterion),
    .profile   (profile),
    .perf_value(perf_value),
    .weight    (weight),
    .last      (last),
    .q_full    (q_full),
    .push      (q_push),
    .op        (q_din)
  );

  mrs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .din     (q_din),
    .full    (q_full),
    .pop     (q_pop),
    .dout    (q_dout),
    .nonempty(q_nonempty)
  );

  mrs_back #(
    .MAX_CRITERIA(MAX_CRITERIA),
    .MAX_PROFILES(MAX_PROFILES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_dout),
    .head_valid(q_nonempty),
    .pop       (q_pop),
    .lambda    (lambda),
    .piu       (piu),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .category  (category)
  );

endmodule
